>>> design/hbp_pkg.sv
// shared types and constants for the huffman bit packer
// payload structs, command codes, table entry type and length helper
// no dependencies
package hbp_pkg;

  localparam int SYMBOL_COUNT  = 256;
  localparam int MAX_CODE_BITS = 32;
  localparam int BYTE_BITS     = 8;
  localparam int CODE_BITS     = 32;
  localparam int LEN_BITS      = 6;
  localparam int SYM_BITS      = 8;
  localparam int ADDR_W        = $clog2(SYMBOL_COUNT);
  localparam int REM_W         = $clog2(MAX_CODE_BITS + 1);
  localparam int CODE_IDX_W    = $clog2(CODE_BITS);
  localparam int CNT_W         = $clog2(BYTE_BITS);

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [SYM_BITS-1:0] symbol;
    logic [CODE_BITS-1:0] code_value;
    logic [LEN_BITS-1:0] code_length;
  } in_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] packed_byte;
    logic                 last_of_run;
  } out_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]  len;
    logic [CODE_BITS-1:0] code;
  } entry_t;

  typedef struct packed {
    logic start_enc;
    logic start_flush;
  } pk_ctl_t;

  typedef struct packed {
    logic busy;
  } pk_stat_t;

  // clamp a stored length to the longest code the packer shifts
  function automatic logic [REM_W-1:0] sat_len(input logic [LEN_BITS-1:0] len);
    logic [REM_W-1:0] res;
    if (int'(len) > MAX_CODE_BITS) begin
      res = REM_W'(MAX_CODE_BITS);
    end else begin
      res = REM_W'(len);
    end
    return res;
  endfunction

endpackage

>>> design/hbp_code_ram.sv
// code table memory: one write port, one registered read port
// each entry holds a code value and its bit length
// depends on hbp_pkg
module hbp_code_ram
  import hbp_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [SYMBOL_COUNT];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/hbp_packer.sv
// bit-serial packer shifts one code bit per cycle into the pending byte
// unless its byte is full and the output is stalled; holds pending bits,
// remaining length and the output register; depends on hbp_pkg
module hbp_packer
  import hbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  pk_ctl_t  ctl,
  input  entry_t   entry,
  output pk_stat_t stat,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data
);

  logic [BYTE_BITS-2:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [CODE_BITS-1:0]  code_r, code_nxt;
  logic                  flush_r, flush_nxt;
  logic                  busy_r, busy_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  logic [REM_W-1:0]      pos;
  logic [CODE_IDX_W-1:0] idx;
  logic                  bit_in;
  logic                  full;
  logic                  can_emit;
  logic                  step;
  logic                  done;
  logic [REM_W-1:0]      start_len;

  assign pos       = rem_r - REM_W'(1);
  assign idx       = CODE_IDX_W'(pos);
  assign bit_in    = !flush_r && (int'(pos) < CODE_BITS) && code_r[idx];
  assign full      = (cnt_r == CNT_W'(BYTE_BITS - 1));
  assign can_emit  = !out_valid_r || !out_stall;
  assign step      = busy_r && (!full || can_emit);
  assign done      = flush_r ? full : (rem_r == REM_W'(1));
  assign start_len = sat_len(entry.len);

  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    code_nxt      = code_r;
    flush_nxt     = flush_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (ctl.start_enc) begin
      code_nxt  = entry.code;
      rem_nxt   = start_len;
      flush_nxt = 1'b0;
      busy_nxt  = (start_len != '0);
    end else if (ctl.start_flush) begin
      flush_nxt = 1'b1;
      busy_nxt  = (cnt_r != '0);
    end else if (step) begin
      if (full) begin
        acc_nxt                  = '0;
        cnt_nxt                  = '0;
        out_valid_nxt            = 1'b1;
        out_data_nxt.packed_byte = {acc_r, bit_in};
        // last byte on a flush, or when fewer than a byte of bits remain
        out_data_nxt.last_of_run = flush_r || (rem_r <= REM_W'(BYTE_BITS));
      end else begin
        acc_nxt = {acc_r[BYTE_BITS-3:0], bit_in};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (!flush_r) begin
        rem_nxt = pos;
      end
      busy_nxt = !done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      flush_r     <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      flush_r     <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    code_r     <= code_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.busy = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/huffman_bit_packer.sv
// huffman bit packer top level: command sequencer, code table and packer
// input channel takes load, encode and flush transactions; output gives bytes
// depends on hbp_pkg, hbp_code_ram, hbp_packer
//
// usage:
//   in_valid/in_stall/in_data carry commands. a load writes one table entry
//   and leaves in_stall low. an encode reads the table, then shifts the code
//   out one bit per cycle while no finished byte waits on a stalled output;
//   a flush pads the pending bits with zeros up to a full byte when bits are
//   pending. in_stall is high while an encode or flush is being worked on.
//   out_valid/out_stall/out_data carry finished bytes, first code bit in
//   bit 7; last_of_run marks the final byte caused by one transaction.
//   the output register lets the next input be taken while a byte waits;
//   when out_stall holds a byte, the packer halts only when it completes
//   the next byte. reset clears the pending bits and the handshake state;
//   the table keeps no reset value and must be loaded before its symbols
//   are encoded.
module huffman_bit_packer
  import hbp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RUN
  } state_t;

  state_t   state_r, state_nxt;
  logic     accept;
  logic     in_range;
  logic     wr_en;
  logic     rd_en;
  entry_t   wr_data;
  entry_t   rd_data;
  pk_ctl_t  ctl;
  pk_stat_t stat;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = ({1'b0, in_data.symbol} < (SYM_BITS + 1)'(SYMBOL_COUNT));

  assign wr_data.len  = in_data.code_length;
  assign wr_data.code = in_data.code_value;

  always_comb begin
    state_nxt       = state_r;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    ctl.start_enc   = 1'b0;
    ctl.start_flush = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.command)
            CMD_LOAD: begin
              wr_en = in_range;
            end
            CMD_ENCODE: begin
              if (in_range) begin
                rd_en     = 1'b1;
                state_nxt = ST_READ;
              end
            end
            CMD_FLUSH: begin
              ctl.start_flush = 1'b1;
              state_nxt       = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        ctl.start_enc = 1'b1;
        state_nxt     = ST_RUN;
      end
      ST_RUN: begin
        if (!stat.busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  hbp_code_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.symbol[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (in_data.symbol[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  hbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .entry     (rd_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sim/huffman_bit_packer_test.sv
`timescale 1ns / 100ps
// self-checking bench for huffman_bit_packer: table loads, symbol encodes and flushes
// keeps its own code table and pending byte, checks each packed byte in order; needs hbp_pkg
module huffman_bit_packer_test;
  import hbp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_TXNS  = 400;
  localparam int HOLD_AT_TXN  = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int SYNC_AT_TXN  = 320;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {PACE_FREE, PACE_FULL, PACE_SPARSE} pace_t;

  typedef struct packed {
    in_t        txn;
    logic [4:0] gap;
    logic       sync;
  } queued_txn_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  queued_txn_t send_q[$];
  out_t        bytes_due[$];
  logic [7:0]  known_syms[$];
  bit          is_known[SYMBOL_COUNT];

  // shadow of the packer: code table and the partial byte
  logic [CODE_BITS-1:0] code_tab[SYMBOL_COUNT];
  logic [LEN_BITS-1:0]  len_tab[SYMBOL_COUNT];
  logic [6:0]           held_bits = '0;
  logic [2:0]           held_count = '0;

  int txns_total = 0;
  int txns_taken = 0;
  int bytes_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int n_loads = 0;
  int n_encodes = 0;
  int n_flushes = 0;
  int n_unused = 0;

  queued_txn_t next_txn;
  bit          have_next = 1'b0;
  int          wait_left = 0;

  pace_t rx_pace = PACE_FREE;
  int    stall_left = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  out_t  byte_want;

  huffman_bit_packer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void queue_txn(logic [1:0] cmd, logic [7:0] sym, logic [31:0] val,
                                    logic [5:0] len, int gap, bit sync);
    queued_txn_t q;
    q.txn.command     = cmd;
    q.txn.symbol      = sym;
    q.txn.code_value  = val;
    q.txn.code_length = len;
    q.gap             = 5'(gap);
    q.sync            = sync;
    send_q.push_back(q);
    txns_total++;
    if (cmd == CMD_LOAD && !is_known[sym]) begin
      is_known[sym] = 1'b1;
      known_syms.push_back(sym);
    end
  endfunction

  // works out the bytes one accepted transaction produces
  task automatic predict_bytes(input in_t t);
    logic [7:0] acc;
    logic [7:0] widened;
    logic [7:0] run[4];
    out_t       b;
    int         cnt;
    int         len;
    int         nb;
    nb = 0;
    case (t.command)
      CMD_LOAD: begin
        code_tab[t.symbol] = t.code_value;
        len_tab[t.symbol]  = t.code_length;
        n_loads++;
      end
      CMD_ENCODE: begin
        acc = {1'b0, held_bits};
        cnt = int'(held_count);
        len = int'(len_tab[t.symbol]);
        if (len > MAX_CODE_BITS) len = MAX_CODE_BITS;
        for (int pos = len - 1; pos >= 0; pos--) begin
          acc = {acc[6:0], code_tab[t.symbol][pos]};
          cnt++;
          if (cnt == BYTE_BITS) begin
            run[nb] = acc;
            nb++;
            acc = '0;
            cnt = 0;
          end
        end
        held_bits  = acc[6:0];
        held_count = 3'(cnt);
        n_encodes++;
      end
      CMD_FLUSH: begin
        if (held_count != 0) begin
          widened    = {1'b0, held_bits};
          run[0]     = widened << (BYTE_BITS - int'(held_count));
          nb         = 1;
          held_bits  = '0;
          held_count = '0;
        end
        n_flushes++;
      end
      default: n_unused++;
    endcase
    for (int i = 0; i < nb; i++) begin
      b.packed_byte = run[i];
      b.last_of_run = (i == nb - 1);
      bytes_due.push_back(b);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // driver: offers queued transactions, holds payload while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_bytes(in_data);
        txns_taken++;
      end
      // a sync transaction waits until every expected byte is out
      if (!have_next && send_q.size() > 0 && !(send_q[0].sync && bytes_due.size() != 0)) begin
        next_txn  = send_q.pop_front();
        have_next = 1'b1;
        wait_left = int'(next_txn.gap);
      end
      if (have_next && wait_left == 0) begin
        in_valid  <= 1'b1;
        in_data   <= next_txn.txn;
        have_next = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (have_next) wait_left--;
      end
    end
  end

  // monitor and receiver: checks each byte, draws stalls, one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (bytes_due.size() == 0) begin
          report_mismatch($sformatf("byte %02h arrived with nothing expected",
                                    out_data.packed_byte));
        end else begin
          byte_want = bytes_due.pop_front();
          if (out_data.packed_byte !== byte_want.packed_byte)
            report_mismatch($sformatf("byte %0d: packed_byte %02h, expected %02h",
                                      bytes_checked, out_data.packed_byte,
                                      byte_want.packed_byte));
          if (out_data.last_of_run !== byte_want.last_of_run)
            report_mismatch($sformatf("byte %0d: last_of_run %b, expected %b", bytes_checked,
                                      out_data.last_of_run, byte_want.last_of_run));
        end
        if (bytes_checked % 24 == 0) rx_pace = pace_t'($urandom_range(0, 2));
        case (rx_pace)
          PACE_FREE: stall_left = 0;
          PACE_FULL: stall_left = $urandom_range(0, 16);
          default:   stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
      end
      if (!hold_done && txns_taken >= HOLD_AT_TXN) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles: %0d of %0d transactions taken, %0d bytes pending",
               cycle_count, txns_taken, txns_total, bytes_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    pace_t      tx_pace;
    int         counted;
    int         roll;
    int         gap;
    logic [5:0] len_pick;
    logic [7:0] sym;

    // directed: zero length, full 32-bit code, overlong lengths, byte boundaries
    queue_txn(CMD_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0, 0, 1'b0);
    queue_txn(CMD_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32, 0, 1'b0);
    queue_txn(CMD_LOAD, 8'd1, 32'h0000_0001, 6'd1, 0, 1'b0);
    queue_txn(CMD_LOAD, 8'd2, 32'hAAAA_AAAA, 6'd63, 0, 1'b0);
    queue_txn(CMD_LOAD, 8'd128, 32'h8000_0001, 6'd33, 0, 1'b0);
    queue_txn(CMD_LOAD, 8'd3, 32'hFFFF_FFF5, 6'd3, 0, 1'b0);
    queue_txn(CMD_LOAD, 8'd4, 32'h0000_005A, 6'd7, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd0, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_FLUSH, 8'd0, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd255, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd1, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd255, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_FLUSH, 8'd0, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd4, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd1, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd2, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd3, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd128, 32'hFFFF_FFFF, 6'h3F, 0, 1'b0);
    queue_txn(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 0, 1'b0);
    queue_txn(CMD_LOAD, 8'd1, 32'h0000_00C3, 6'd8, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd1, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_FLUSH, 8'd0, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_ENCODE, 8'd3, 32'h0, 6'd0, 0, 1'b0);
    queue_txn(CMD_FLUSH, 8'd0, 32'h0, 6'd0, 0, 1'b0);

    // random: mostly loads of short codes and encodes of loaded symbols
    counted = 0;
    tx_pace = PACE_FREE;
    while (counted < RANDOM_TXNS) begin
      if (counted % 40 == 0) tx_pace = pace_t'($urandom_range(0, 2));
      if (txns_total >= HOLD_AT_TXN - 10 && txns_total < HOLD_AT_TXN + 60) begin
        gap = 0;  // keep offering while the receiver holds off
      end else begin
        case (tx_pace)
          PACE_FREE: gap = 0;
          PACE_FULL: gap = $urandom_range(0, 16);
          default:   gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        roll = $urandom_range(0, 99);
        if (roll < 70)      len_pick = 6'($urandom_range(1, 12));
        else if (roll < 80) len_pick = 6'd0;
        else if (roll < 92) len_pick = 6'($urandom_range(13, 32));
        else                len_pick = 6'($urandom_range(33, 63));
        queue_txn(CMD_LOAD, 8'($urandom_range(0, 255)), $urandom(), len_pick, gap,
                  txns_total == SYNC_AT_TXN);
        counted++;
      end else if (roll < 78) begin
        sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
        queue_txn(CMD_ENCODE, sym, $urandom(), 6'($urandom_range(0, 63)), gap,
                  txns_total == SYNC_AT_TXN);
        counted++;
      end else if (roll < 93) begin
        queue_txn(CMD_FLUSH, 8'($urandom_range(0, 255)), $urandom(),
                  6'($urandom_range(0, 63)), gap, txns_total == SYNC_AT_TXN);
        counted++;
      end else begin
        queue_txn(CMD_UNUSED, 8'($urandom_range(0, 255)), $urandom(),
                  6'($urandom_range(0, 63)), gap, txns_total == SYNC_AT_TXN);
      end
    end
    queue_txn(CMD_FLUSH, 8'd0, 32'h0, 6'd0, 0, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (txns_taken < txns_total) @(posedge clk);
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d encodes, %0d flushes, %0d unused commands",
             n_loads, n_encodes, n_flushes, n_unused);
    $display("%0d packed bytes compared, %0d mismatches", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
